@@ hw/rtl/rpn_stack_machine_defines.svh @@
// Assertion macros shared by the RPN stack machine RTL.
`ifndef RPN_STACK_MACHINE_DEFINES_SVH
`define RPN_STACK_MACHINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsm assertion failed");

`endif

@@ hw/rtl/rsm_pkg.sv @@
// Types, codes and sizes shared by the RPN stack machine modules.
package rsm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int LIT_W       = 31;
    localparam int DEPTH_W     = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_PRINT = 3'd4,
        OP_SWAP  = 3'd5,
        OP_DUP   = 3'd6,
        OP_DROP  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [LIT_W-1:0] literal_value;
    } in_item_t;

    typedef struct packed {
        logic               print_valid;
        logic signed [31:0] print_value;
        logic [1:0]         status;
        logic [DEPTH_W-1:0] stack_depth;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [LIT_W-1:0] literal;
        logic             need_one;
        logic             need_two;
        logic             grows;
    } uop_t;

endpackage

@@ hw/rtl/rsm_front.sv @@
// Front end: accepts items, classifies the operation and queues it for execution.
module rsm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rsm_pkg::in_item_t in_item,
    output logic              uop_valid,
    input  logic              uop_ready,
    output rsm_pkg::uop_t     uop
);
    import rsm_pkg::*;

    `include "rpn_stack_machine_defines.svh"

    uop_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;
    uop_t              decoded;

    always_comb
    begin
        decoded.op       = op_t'(in_item.cmd);
        decoded.literal  = in_item.literal_value;
        decoded.need_one = 1'b0;
        decoded.need_two = 1'b0;
        decoded.grows    = 1'b0;
        unique case (decoded.op)
            OP_PUSH:
            begin
                decoded.grows = 1'b1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_SWAP:
            begin
                decoded.need_two = 1'b1;
            end
            OP_DUP:
            begin
                decoded.need_one = 1'b1;
                decoded.grows    = 1'b1;
            end
            OP_PRINT, OP_DROP:
            begin
                decoded.need_one = 1'b1;
            end
            default:
            begin
                decoded.grows = 1'b0;
            end
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign uop_valid = (count_reg != '0);
    assign uop       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = uop_valid && uop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

    `RSM_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `RSM_ASSERT_NEXT(a_push_only_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `RSM_ASSERT_IMPL(a_full_blocks, clk, rst_n, count_reg == QCNT_W'(QUEUE_DEPTH), !push)

endmodule

@@ hw/rtl/rsm_back.sv @@
// Back end: executes queued operations on the cached top entries and the stack memory.
module rsm_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               uop_valid,
    output logic               uop_ready,
    input  rsm_pkg::uop_t      uop,
    output logic               out_valid,
    input  logic               out_ready,
    output rsm_pkg::out_item_t out_item
);
    import rsm_pkg::*;

    `include "rpn_stack_machine_defines.svh"

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_FILL = 2'b10
    } back_state_t;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [DATA_W-1:0] top_reg;
    logic [DATA_W-1:0] top_next;
    logic [DATA_W-1:0] nos_reg;
    logic [DATA_W-1:0] nos_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic              exec;
    logic              underflow;
    logic              overflow;
    logic [SP_W-1:0]   sp_minus2;
    logic [SP_W-1:0]   sp_minus3;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] arith;
    logic [DATA_W-1:0] product;
    status_t           status;

    assign uop_ready = (state_reg == S_RUN) && (!out_valid_reg || out_ready);
    assign exec      = uop_valid && uop_ready;
    assign sp_minus2 = sp_reg - SP_W'(2);
    assign sp_minus3 = sp_reg - SP_W'(3);
    assign mem_waddr = sp_minus2[ADDR_W-1:0];
    assign mem_raddr = sp_minus3[ADDR_W-1:0];
    assign product   = nos_reg * top_reg;
    assign underflow = (uop.need_two && (sp_reg < SP_W'(2)))
                    || (uop.need_one && (sp_reg == '0));
    assign overflow  = uop.grows && (sp_reg == SP_W'(STACK_DEPTH));

    always_comb
    begin
        case (uop.op)
            OP_ADD:  arith = nos_reg + top_reg;
            OP_SUB:  arith = nos_reg - top_reg;
            default: arith = product;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        nos_next       = nos_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        status         = ST_OK;

        unique case (state_reg)
            S_RUN:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
                if (exec)
                begin
                    out_item_next.print_valid = 1'b0;
                    out_item_next.print_value = '0;
                    if (underflow)
                    begin
                        status = ST_UNDER;
                    end
                    else if (overflow)
                    begin
                        status = ST_OVER;
                    end
                    else
                    begin
                        unique case (uop.op)
                            OP_PUSH:
                            begin
                                mem_we   = (sp_reg >= SP_W'(2));
                                nos_next = top_reg;
                                top_next = {1'b0, uop.literal};
                                sp_next  = sp_reg + 1'b1;
                            end
                            OP_DUP:
                            begin
                                mem_we   = (sp_reg >= SP_W'(2));
                                nos_next = top_reg;
                                sp_next  = sp_reg + 1'b1;
                            end
                            OP_ADD, OP_SUB, OP_MUL:
                            begin
                                top_next = arith;
                                sp_next  = sp_reg - 1'b1;
                                if (sp_reg >= SP_W'(3))
                                begin
                                    state_next = S_FILL;
                                end
                            end
                            OP_DROP:
                            begin
                                top_next = nos_reg;
                                sp_next  = sp_reg - 1'b1;
                                if (sp_reg >= SP_W'(3))
                                begin
                                    state_next = S_FILL;
                                end
                            end
                            OP_SWAP:
                            begin
                                top_next = nos_reg;
                                nos_next = top_reg;
                            end
                            OP_PRINT:
                            begin
                                out_item_next.print_valid = 1'b1;
                                out_item_next.print_value = $signed(top_reg);
                            end
                            default:
                            begin
                                sp_next = sp_reg;
                            end
                        endcase
                    end
                    out_item_next.status      = status;
                    out_item_next.stack_depth = DEPTH_W'(sp_next);
                    out_valid_next            = 1'b1;
                end
            end
            S_FILL:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                end
                nos_next   = rd_data_reg;
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        nos_reg      <= nos_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= nos_reg;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `RSM_ASSERT_IMPL(a_sp_range, clk, rst_n, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `RSM_ASSERT_NEXT(a_fill_one_cycle, clk, rst_n, state_reg == S_FILL, state_reg == S_RUN)
    `RSM_ASSERT_NEXT(a_error_keeps_sp, clk, rst_n, exec && (underflow || overflow), sp_reg == $past(sp_reg))
    `RSM_ASSERT_NEXT(a_exec_shows_result, clk, rst_n, exec, out_valid_reg)

endmodule

@@ hw/rtl/rpn_stack_machine.sv @@
// RPN stack machine: decoded stack instructions on a stack of 32-bit signed integers.
//
// Input channel (in_valid, in_ready, in_item) carries one decoded op per item:
// push literal, add, sub, mul, print, swap, dup or drop. Output channel
// (out_valid, out_ready, out_item) returns exactly one result per op, in order:
// the printed value for a successful print, a status (ok, underflow, overflow)
// and the stack depth after the op. A failing op leaves the stack unchanged.
// The result is registered in the back end's output register once the op
// leaves the queue. Push, print, swap and dup are done in the S_RUN state;
// add, sub, mul and drop also pass through S_FILL when two or more entries
// remain, that state being the registered read of the stack memory that
// refills the cached second entry. A two-entry
// queue sits between the decode front end and the execution back end, so input
// is still taken while the back end waits. When the receiver stalls, the
// result register holds and the queue fills, after which in_ready falls.
// Reset empties the stack and the queue; no memory clearing pass is needed.
module rpn_stack_machine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsm_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rsm_pkg::out_item_t out_item
);
    import rsm_pkg::*;

    logic uop_valid;
    logic uop_ready;
    uop_t uop;

    rsm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .uop_valid (uop_valid),
        .uop_ready (uop_ready),
        .uop       (uop)
    );

    rsm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop_valid (uop_valid),
        .uop_ready (uop_ready),
        .uop       (uop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
